FILE: rtl/isotropic_diffusion_stencil_macros.svh
// Assertion macros for the isotropic diffusion stencil checker.
// Each macro expects clk and rst_n in scope where it is used.
`ifndef ISOTROPIC_DIFFUSION_STENCIL_MACROS_SVH
`define ISOTROPIC_DIFFUSION_STENCIL_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define IDS_ASSERT_IMP(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IDS_ASSERT_NXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

FILE: rtl/ids_pkg.sv
// Shared types and constants of the isotropic diffusion stencil.
// No dependencies; imported by every RTL module of the block.
package ids_pkg;

    localparam int PIX_W       = 16;
    localparam int IDX_W       = 10;
    localparam int KAPPA_W     = 16;
    localparam int SIZE_CFG_W  = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int LAP_W       = 19;
    localparam int PROD_W      = 36;
    localparam int FIFO_DEPTH  = 8;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [KAPPA_W-1:0]    KAPPA_RST = 16'd6554;
    localparam logic [SIZE_CFG_W-1:0] SIZE_RST  = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KAPPA  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } ids_cfg_idx_t;

    // What the stencil stages need to know about one accepted pixel
    typedef struct packed {
        logic             emit_a;   // result for the row above
        logic             emit_b;   // copied result for the last row
        logic             border;   // row above is a border pixel
        logic             last_a;
        logic             eof_b;
        logic [IDX_W-1:0] row_a;
        logic [IDX_W-1:0] row_b;
        logic [IDX_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } ids_tag_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
        logic             eof;
    } ids_result_t;

endpackage

FILE: rtl/ids_line_store.sv
// Two line memories of the stencil: newer line (two read ports) and older line.
// Synchronous, read-first, registered read data. Uses ids_pkg.
module ids_line_store
    import ids_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEF_MAX_WIDTH)
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_c,
    input  logic [AW-1:0]    rd_addr_e,
    input  logic             new_we,
    input  logic [PIX_W-1:0] new_wdata,
    input  logic             old_we,
    input  logic [AW-1:0]    old_waddr,
    input  logic [PIX_W-1:0] old_wdata,
    output logic [PIX_W-1:0] new_c_rd,
    output logic [PIX_W-1:0] new_e_rd,
    output logic [PIX_W-1:0] old_rd
);

    logic [PIX_W-1:0] newer_mem [DEPTH];
    logic [PIX_W-1:0] older_mem [DEPTH];

    // newer line is written at the centre read address in the same cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            new_c_rd <= newer_mem[rd_addr_c];
            new_e_rd <= newer_mem[rd_addr_e];
        end
        if (new_we)
        begin
            newer_mem[rd_addr_c] <= new_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            old_rd <= older_mem[rd_addr_c];
        end
        if (old_we)
        begin
            older_mem[old_waddr] <= old_wdata;
        end
    end

endmodule

FILE: rtl/ids_stencil_core.sv
// Stencil arithmetic: forwarding and Laplacian, multiply by kappa, shift and saturate.
// Three stages after the line store read. Uses ids_pkg.
module ids_stencil_core
    import ids_pkg::*;
#(
    parameter int AW = $clog2(DEF_MAX_WIDTH)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  ids_tag_t           tag_in,
    input  logic [AW-1:0]      col_in,
    input  logic [KAPPA_W-1:0] kappa,
    input  logic [PIX_W-1:0]   new_c_rd,
    input  logic [PIX_W-1:0]   new_e_rd,
    input  logic [PIX_W-1:0]   old_rd,
    output logic               old_we,
    output logic [AW-1:0]      old_waddr,
    output logic [PIX_W-1:0]   old_wdata,
    output logic               push_a,
    output logic               push_b,
    output ids_result_t        res_a,
    output ids_result_t        res_b
);

    logic                     s1_valid_reg;
    ids_tag_t                 s1_tag_reg;
    logic [AW-1:0]            s1_col_reg;
    logic                     s1_fwd_reg;
    logic                     s1_fwd_next;
    logic [PIX_W-1:0]         prev_reg;

    logic                     s2_valid_reg;
    ids_tag_t                 s2_tag_reg;
    logic [PIX_W-1:0]         s2_centre_reg;
    logic signed [LAP_W-1:0]  s2_lap_reg;

    logic                     s3_valid_reg;
    ids_tag_t                 s3_tag_reg;
    logic [PIX_W-1:0]         s3_centre_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;

    logic [PIX_W-1:0]         centre;
    logic [PIX_W-1:0]         north;
    logic [LAP_W-2:0]         sum4;
    logic [LAP_W-2:0]         centre4;
    logic signed [LAP_W-1:0]  lap;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-17:0] delta;
    logic signed [PROD_W-15:0] sum_res;
    logic [PIX_W-1:0]         smoothed;

    // older line write of the item in stage 1 collides with a read issued now
    assign s1_fwd_next = take && s1_valid_reg && (s1_col_reg == col_in);

    assign centre  = new_c_rd;
    assign north   = s1_fwd_reg ? prev_reg : old_rd;
    assign sum4    = (LAP_W-1)'(north) + (LAP_W-1)'(prev_reg)
                   + (LAP_W-1)'(new_e_rd) + (LAP_W-1)'(s1_tag_reg.pix);
    assign centre4 = {centre, 2'b00};
    assign lap     = $signed({1'b0, sum4}) - $signed({1'b0, centre4});

    assign old_we    = s1_valid_reg;
    assign old_waddr = s1_col_reg;
    assign old_wdata = centre;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            prev_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                prev_reg <= centre;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_tag_reg <= tag_in;
            s1_col_reg <= col_in;
            s1_fwd_reg <= s1_fwd_next;
        end
        s2_tag_reg    <= s1_tag_reg;
        s2_centre_reg <= centre;
        s2_lap_reg    <= lap;
        s3_tag_reg    <= s2_tag_reg;
        s3_centre_reg <= s2_centre_reg;
        s3_prod_reg   <= prod;
    end

    assign prod = $signed({1'b0, kappa}) * s2_lap_reg;

    // arithmetic shift floors toward minus infinity
    assign delta   = s3_prod_reg[PROD_W-1:16];
    assign sum_res = $signed({5'b0, s3_centre_reg}) + (PROD_W-14)'(delta);

    always_comb
    begin
        priority if (sum_res < 0)
            smoothed = '0;
        else if (sum_res > $signed((PROD_W-14)'(16'hFFFF)))
            smoothed = '1;
        else
            smoothed = sum_res[PIX_W-1:0];
    end

    assign push_a = s3_valid_reg && s3_tag_reg.emit_a;
    assign push_b = s3_valid_reg && s3_tag_reg.emit_b;

    always_comb
    begin
        res_a.pix  = s3_tag_reg.border ? s3_centre_reg : smoothed;
        res_a.row  = s3_tag_reg.row_a;
        res_a.col  = s3_tag_reg.col;
        res_a.last = s3_tag_reg.last_a;
        res_a.eof  = 1'b0;
        res_b.pix  = s3_tag_reg.pix;
        res_b.row  = s3_tag_reg.row_b;
        res_b.col  = s3_tag_reg.col;
        res_b.last = 1'b1;
        res_b.eof  = s3_tag_reg.eof_b;
    end

endmodule

FILE: rtl/ids_result_fifo.sv
// Result queue: takes up to two results per cycle, gives one per transfer.
// Register array with read and write pointers. Uses ids_pkg.
module ids_result_fifo
    import ids_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_a,
    input  logic        push_b,
    input  ids_result_t res_a,
    input  ids_result_t res_b,
    input  logic        pop,
    output logic        valid,
    output ids_result_t head
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    ids_result_t   entry_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [PW-1:0] wr_ptr_1;
    ids_result_t   first;

    assign wr_ptr_1 = wr_ptr_reg + PW'(1);
    assign first    = push_a ? res_a : res_b;

    assign wr_ptr_next = wr_ptr_reg + PW'(push_a) + PW'(push_b);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + CW'(push_a) + CW'(push_b) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_a || push_b)
        begin
            entry_reg[wr_ptr_reg] <= first;
        end
        if (push_a && push_b)
        begin
            entry_reg[wr_ptr_1] <= res_b;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

endmodule

FILE: rtl/isotropic_diffusion_stencil.sv
// One pass of 5-point isotropic diffusion over a raster pixel stream.
// Throughput: one pixel per cycle while result credits remain; the last row brings two
// results per pixel, so there the output side sets the pace.
// Input ready is held by a result credit count against the 8-entry result queue.
// Reset clears valid flags, credits, position and previous pixel, not the line memories.
module isotropic_diffusion_stencil
    import ids_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      pixel_in,
    input  logic                  start_of_frame,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      pixel_out,
    output logic [IDX_W-1:0]      out_row,
    output logic [IDX_W-1:0]      out_col,
    output logic                  last_of_item,
    output logic                  end_of_frame,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int KW  = $clog2(FIFO_DEPTH + 1);
    localparam int W_RST = (SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : int'(SIZE_RST);
    localparam int H_RST = (SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : int'(SIZE_RST);

    logic [KAPPA_W-1:0] kappa_reg;
    logic [WW-1:0]      width_reg;
    logic [HW-1:0]      height_reg;
    logic [AW-1:0]      col_reg;
    logic [AW-1:0]      col_next;
    logic [RW-1:0]      row_reg;
    logic [RW-1:0]      row_next;
    logic [KW-1:0]      credit_reg;
    logic [KW-1:0]      credit_next;

    logic [CFG_DATA_W-1:0] size_val;
    logic [CFG_DATA_W-1:0] width_clamp;
    logic [CFG_DATA_W-1:0] height_clamp;

    logic          take;
    logic          out_xfer;
    logic [WW-1:0] col_base;
    logic [HW-1:0] row_base;
    logic          col_wrap;
    logic [WW-1:0] c0;
    logic [HW-1:0] row_t;
    logic [HW-1:0] r0;
    logic [WW-1:0] c_inc;
    logic [HW-1:0] r_inc;
    logic          at_end;
    logic          last_row;
    logic [AW-1:0] col_addr;
    logic [AW-1:0] east_addr;
    ids_tag_t      tag;

    logic [PIX_W-1:0] new_c_rd;
    logic [PIX_W-1:0] new_e_rd;
    logic [PIX_W-1:0] old_rd;
    logic             old_we;
    logic [AW-1:0]    old_waddr;
    logic [PIX_W-1:0] old_wdata;
    logic             push_a;
    logic             push_b;
    ids_result_t      res_a;
    ids_result_t      res_b;
    ids_result_t      head;

    // ---------------- configuration ----------------
    assign size_val = {{(CFG_DATA_W-SIZE_CFG_W){1'b0}}, cfg_data[SIZE_CFG_W-1:0]};

    always_comb
    begin
        priority if (size_val < CFG_DATA_W'(3))
            width_clamp = CFG_DATA_W'(3);
        else if (size_val > CFG_DATA_W'(MAX_WIDTH))
            width_clamp = CFG_DATA_W'(MAX_WIDTH);
        else
            width_clamp = size_val;

        priority if (size_val < CFG_DATA_W'(3))
            height_clamp = CFG_DATA_W'(3);
        else if (size_val > CFG_DATA_W'(MAX_HEIGHT))
            height_clamp = CFG_DATA_W'(MAX_HEIGHT);
        else
            height_clamp = size_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kappa_reg  <= KAPPA_RST;
            width_reg  <= WW'(W_RST);
            height_reg <= HW'(H_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KAPPA:  kappa_reg  <= cfg_data[KAPPA_W-1:0];
                CFG_WIDTH:  width_reg  <= width_clamp[WW-1:0];
                CFG_HEIGHT: height_reg <= height_clamp[HW-1:0];
                default:    ;
            endcase
        end
    end

    // ---------------- position of the incoming pixel ----------------
    assign take     = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        col_base = start_of_frame ? '0 : WW'(col_reg);
        row_base = start_of_frame ? '0 : HW'(row_reg);
        col_wrap = (col_base >= width_reg);
        c0       = col_wrap ? '0 : col_base;
        row_t    = col_wrap ? row_base + HW'(1) : row_base;
        r0       = (row_t >= height_reg) ? '0 : row_t;

        c_inc    = c0 + WW'(1);
        r_inc    = r0 + HW'(1);
        at_end   = (c_inc >= width_reg);
        last_row = (r0 == height_reg - HW'(1));

        col_next = at_end ? '0 : c_inc[AW-1:0];
        if (at_end)
            row_next = (r_inc >= height_reg) ? '0 : r_inc[RW-1:0];
        else
            row_next = r0[RW-1:0];

        col_addr  = c0[AW-1:0];
        east_addr = (col_addr == AW'(MAX_WIDTH - 1)) ? '0 : col_addr + AW'(1);

        tag.emit_a = (r0 != '0);
        tag.emit_b = last_row;
        tag.border = (r0 == HW'(1)) || (c0 == '0) || at_end;
        tag.last_a = !last_row;
        tag.eof_b  = at_end;
        tag.row_a  = IDX_W'(r0 - HW'(1));
        tag.row_b  = IDX_W'(r0);
        tag.col    = IDX_W'(c0);
        tag.pix    = pixel_in;
    end

    // results promised to the queue but not yet transferred out
    assign credit_next = credit_reg
                       + (take ? KW'(tag.emit_a) + KW'(tag.emit_b) : '0)
                       - KW'(out_xfer);
    assign in_ready = (credit_reg <= KW'(FIFO_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            if (take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // ---------------- datapath ----------------
    ids_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .clk       (clk),
        .rd_en     (take),
        .rd_addr_c (col_addr),
        .rd_addr_e (east_addr),
        .new_we    (take),
        .new_wdata (pixel_in),
        .old_we    (old_we),
        .old_waddr (old_waddr),
        .old_wdata (old_wdata),
        .new_c_rd  (new_c_rd),
        .new_e_rd  (new_e_rd),
        .old_rd    (old_rd)
    );

    ids_stencil_core #(
        .AW (AW)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .tag_in    (tag),
        .col_in    (col_addr),
        .kappa     (kappa_reg),
        .new_c_rd  (new_c_rd),
        .new_e_rd  (new_e_rd),
        .old_rd    (old_rd),
        .old_we    (old_we),
        .old_waddr (old_waddr),
        .old_wdata (old_wdata),
        .push_a    (push_a),
        .push_b    (push_b),
        .res_a     (res_a),
        .res_b     (res_b)
    );

    ids_result_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push_a (push_a),
        .push_b (push_b),
        .res_a  (res_a),
        .res_b  (res_b),
        .pop    (out_xfer),
        .valid  (out_valid),
        .head   (head)
    );

    assign pixel_out    = head.pix;
    assign out_row      = head.row;
    assign out_col      = head.col;
    assign last_of_item = head.last;
    assign end_of_frame = head.eof;

endmodule

FILE: rtl/ids_checker.sv
// Port-level checker for isotropic_diffusion_stencil, attached by bind.
// Uses ids_pkg and isotropic_diffusion_stencil_macros.svh.
`include "isotropic_diffusion_stencil_macros.svh"

module ids_port_checker
    import ids_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_ready,
    input logic [PIX_W-1:0] pixel_out,
    input logic [IDX_W-1:0] out_row,
    input logic [IDX_W-1:0] out_col,
    input logic             last_of_item,
    input logic             end_of_frame
);

    // a stalled result holds
    `IDS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(out_row) && $stable(out_col), "result changed while stalled")

    // frame end is always the final result of its pixel
    `IDS_ASSERT_IMP(a_eof_last, out_valid && end_of_frame, last_of_item, "end_of_frame without last_of_item")

    // first of a pair is followed at once by its partner
    `IDS_ASSERT_NXT(a_pair_next, out_valid && out_ready && !last_of_item, out_valid && last_of_item, "second result of pixel missing")

    // both results of a pixel share the column
    `IDS_ASSERT_NXT(a_pair_col, out_valid && out_ready && !last_of_item, out_col == $past(out_col), "pair column mismatch")

endmodule

bind isotropic_diffusion_stencil ids_port_checker u_ids_checker (.*);
